@@ rtl/hcb_pkg.sv @@
`default_nettype none
package hcb_pkg;

    localparam int SYM_COUNT         = 256;
    localparam int SYM_BITS          = 8;
    localparam int LEN_BITS          = 6;
    localparam int CODE_BITS         = 48;
    localparam int IN_FREQ_BITS      = 31;

    localparam int DEF_NUM_LEAVES    = 256;
    localparam int DEF_MAX_CODE_LEN  = 48;
    localparam int DEF_FREQ_BITS     = 31;

    localparam logic       CMD_LOAD    = 1'b0;
    localparam logic       CMD_READ    = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_UNBUILT  = 2'd3;

    // One write into the symbol code tables.
    typedef struct packed {
        logic                 en;
        logic [SYM_BITS-1:0]  sym;
        logic [LEN_BITS-1:0]  len;
        logic [CODE_BITS-1:0] bits;
    } t_tab_wr;

endpackage
`default_nettype wire

@@ rtl/hcb_tree.sv @@
`default_nettype none
module hcb_tree #(
    parameter int NUM_LEAVES   = 256,
    parameter int MAX_CODE_LEN = 48,
    parameter int FREQ_BITS    = 31
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_ld_en,
    input  wire logic [$clog2(NUM_LEAVES)-1:0]     i_ld_idx,
    input  wire logic [hcb_pkg::SYM_BITS-1:0]      i_ld_sym,
    input  wire logic [FREQ_BITS-1:0]              i_ld_freq,
    input  wire logic                              i_start,
    input  wire logic [$clog2(NUM_LEAVES+1)-1:0]   i_count,
    output logic                                   o_done,
    output hcb_pkg::t_tab_wr                       o_tw
);
    import hcb_pkg::*;

    localparam int ND = 2 * NUM_LEAVES;
    localparam int NW = $clog2(ND);
    localparam int IW = $clog2(NUM_LEAVES);
    localparam int LW = $clog2(NUM_LEAVES + 1);
    localparam int DW = $clog2(MAX_CODE_LEN + 1);
    localparam int SD = MAX_CODE_LEN + 2;
    localparam int SW = $clog2(SD);
    localparam int PW = $clog2(SD + 1);

    typedef enum logic [3:0] {
        T_IDLE, T_ONE, T_RD, T_DEC, T_JOIN, T_WI, T_POP, T_ENT, T_ACT, T_PUSH
    } t_state;

    logic [SYM_BITS-1:0]     leaf_mem [NUM_LEAVES];
    logic [FREQ_BITS-1:0]    freq_mem [ND];
    logic [NW-1:0]           left_mem [ND];
    logic [NW-1:0]           right_mem [ND];
    logic [NW-1:0]           stk_node [SD];
    logic [DW-1:0]           stk_depth [SD];
    logic [MAX_CODE_LEN-1:0] stk_code [SD];

    t_state r_state;
    logic [NW-1:0] r_bl, r_bi, r_fill, r_root, r_ja, r_jb;
    logic [LW-1:0] r_m;
    logic          r_first;
    logic [2:0]    r_step;
    logic [FREQ_BITS-1:0] r_fa, r_fb, r_fc, r_fd, r_jfa, r_jfb, r_fq_rd;
    logic [PW-1:0] r_sp;
    logic [NW-1:0] r_e_node, r_stk_node_rd, r_left_rd, r_right_rd;
    logic [DW-1:0] r_e_depth, r_stk_depth_rd;
    logic [MAX_CODE_LEN-1:0] r_e_code, r_stk_code_rd;
    logic [SYM_BITS-1:0] r_sym_rd;
    logic          r_done;

    logic [NW-1:0] fq_addr, bl1, bi1;
    logic          bl_ok, bl1_ok, bi1_ok, is_leaf, is_node, can_push;
    logic [NW-1:0] n_bl, n_bi, n_ja, n_jb;
    logic [FREQ_BITS-1:0] n_jfa, n_jfb;
    logic [63:0]   code_ext;

    assign bl1    = r_bl + 1'b1;
    assign bi1    = r_bi + 1'b1;
    assign bl_ok  = r_bl < NW'(i_count);
    assign bl1_ok = bl1 < NW'(i_count);
    assign bi1_ok = bi1 < r_fill;

    always_comb begin
        case (r_step)
            3'd0:    fq_addr = r_bl;
            3'd1:    fq_addr = bl1;
            3'd2:    fq_addr = r_bi;
            default: fq_addr = bi1;
        endcase
    end

    // Merge choice with the two-queue tie rules; the leaf is the left child.
    always_comb begin
        n_bl  = r_bl;
        n_bi  = r_bi;
        n_ja  = r_bl;
        n_jb  = r_bi;
        n_jfa = r_fa;
        n_jfb = r_fc;
        if (r_first || (bl_ok && r_fc > r_fa && bl1_ok && r_fb < r_fc)) begin
            n_jb  = bl1;
            n_jfb = r_fb;
            n_bl  = r_bl + NW'(2);
        end else if (!bl_ok || (r_fc <= r_fa && bi1_ok && r_fd < r_fa)) begin
            n_ja  = r_bi;
            n_jb  = bi1;
            n_jfa = r_fc;
            n_jfb = r_fd;
            n_bi  = r_bi + NW'(2);
        end else begin
            n_bl = bl1;
            n_bi = bi1;
        end
    end

    assign is_leaf  = r_e_node < NW'(NUM_LEAVES);
    assign is_node  = r_e_node < NW'(ND - 1);
    assign can_push = (r_e_depth < DW'(MAX_CODE_LEN)) &&
                      ((PW + 1)'(r_sp) + (PW + 1)'(2) <= (PW + 1)'(SD));
    assign code_ext = 64'(r_e_code);

    always_comb begin
        o_tw = '0;
        if (r_state == T_ONE) begin
            o_tw.en   = 1'b1;
            o_tw.sym  = r_sym_rd;
            o_tw.len  = LEN_BITS'(1);
            o_tw.bits = CODE_BITS'(1);
        end else if (r_state == T_ACT && is_node && is_leaf) begin
            o_tw.en   = 1'b1;
            o_tw.sym  = r_sym_rd;
            o_tw.len  = LEN_BITS'(r_e_depth);
            o_tw.bits = code_ext[CODE_BITS-1:0];
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_ld_en) begin
            leaf_mem[i_ld_idx] <= i_ld_sym;
        end
        if (r_state == T_IDLE && i_start) begin
            r_sym_rd <= leaf_mem[0];
        end else if (r_state == T_ENT) begin
            r_sym_rd <= leaf_mem[r_stk_node_rd[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_en) begin
            freq_mem[NW'(i_ld_idx)] <= i_ld_freq;
        end else if (r_state == T_JOIN) begin
            freq_mem[r_fill] <= r_jfa + r_jfb;
        end
        r_fq_rd <= freq_mem[fq_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_JOIN) begin
            left_mem[r_fill]  <= r_ja;
            right_mem[r_fill] <= r_jb;
        end
        if (r_state == T_ENT) begin
            r_left_rd  <= left_mem[r_stk_node_rd];
            r_right_rd <= right_mem[r_stk_node_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_WI) begin
            stk_node[0]  <= r_root;
            stk_depth[0] <= '0;
            stk_code[0]  <= '0;
        end else if (r_state == T_ACT) begin
            stk_node[SW'(r_sp)]  <= r_right_rd;
            stk_depth[SW'(r_sp)] <= r_e_depth + 1'b1;
            stk_code[SW'(r_sp)]  <= {r_e_code[MAX_CODE_LEN-2:0], 1'b1};
        end else if (r_state == T_PUSH) begin
            stk_node[SW'(r_sp)]  <= r_left_rd;
            stk_depth[SW'(r_sp)] <= r_e_depth;
            stk_code[SW'(r_sp)]  <= {r_e_code[MAX_CODE_LEN-2:0], 1'b0};
        end
        if (r_state == T_POP && r_sp != '0) begin
            r_stk_node_rd  <= stk_node[SW'(r_sp - 1'b1)];
            r_stk_depth_rd <= stk_depth[SW'(r_sp - 1'b1)];
            r_stk_code_rd  <= stk_code[SW'(r_sp - 1'b1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
            r_sp    <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                T_IDLE: begin
                    if (i_start) begin
                        r_bl    <= '0;
                        r_bi    <= NW'(NUM_LEAVES);
                        r_fill  <= NW'(NUM_LEAVES);
                        r_m     <= '0;
                        r_first <= 1'b1;
                        r_step  <= '0;
                        r_state <= (i_count == LW'(1)) ? T_ONE : T_RD;
                    end
                end
                T_ONE: begin
                    r_done  <= 1'b1;
                    r_state <= T_IDLE;
                end
                T_RD: begin
                    case (r_step)
                        3'd1:    r_fa <= r_fq_rd;
                        3'd2:    r_fb <= r_fq_rd;
                        3'd3:    r_fc <= r_fq_rd;
                        3'd4:    r_fd <= r_fq_rd;
                        default: r_fa <= r_fa;
                    endcase
                    if (r_step == 3'd4) begin
                        r_state <= T_DEC;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                T_DEC: begin
                    r_bl    <= n_bl;
                    r_bi    <= n_bi;
                    r_ja    <= n_ja;
                    r_jb    <= n_jb;
                    r_jfa   <= n_jfa;
                    r_jfb   <= n_jfb;
                    r_state <= T_JOIN;
                end
                T_JOIN: begin
                    r_fill  <= r_fill + 1'b1;
                    r_m     <= r_m + 1'b1;
                    r_first <= 1'b0;
                    r_step  <= '0;
                    if (r_m + 1'b1 == i_count - 1'b1) begin
                        r_root  <= r_fill;
                        r_state <= T_WI;
                    end else begin
                        r_state <= T_RD;
                    end
                end
                T_WI: begin
                    r_sp    <= PW'(1);
                    r_state <= T_POP;
                end
                T_POP: begin
                    if (r_sp == '0) begin
                        r_done  <= 1'b1;
                        r_state <= T_IDLE;
                    end else begin
                        r_sp    <= r_sp - 1'b1;
                        r_state <= T_ENT;
                    end
                end
                T_ENT: begin
                    r_e_node  <= r_stk_node_rd;
                    r_e_depth <= r_stk_depth_rd;
                    r_e_code  <= r_stk_code_rd;
                    r_state   <= T_ACT;
                end
                T_ACT: begin
                    if (is_node && !is_leaf && can_push) begin
                        r_sp      <= r_sp + 1'b1;
                        r_e_depth <= r_e_depth + 1'b1;
                        r_state   <= T_PUSH;
                    end else begin
                        r_state <= T_POP;
                    end
                end
                T_PUSH: begin
                    r_sp    <= r_sp + 1'b1;
                    r_state <= T_POP;
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/huffman_code_builder_top.sv @@
`default_nettype none
// Huffman code builder. Leaves are loaded one per transfer, sorted by
// frequency, and the load marked last builds the code tree and assigns
// codes; read transfers then return the code of one symbol. A load not
// marked last is answered from idle, a read via S_READ, a failed build via
// S_CHECK. Builds are paced by the single read port of the node frequency
// memory, read four times in turn per merge; the code walk over the stack
// memory takes pop, fetch and act steps per node, plus a push per internal
// node. The code length table is cleared at once through per-symbol valid
// bits, so there is no clearing pass after reset or before a build.
module huffman_code_builder_top #(
    parameter int NUM_LEAVES   = hcb_pkg::DEF_NUM_LEAVES,
    parameter int MAX_CODE_LEN = hcb_pkg::DEF_MAX_CODE_LEN,
    parameter int FREQ_BITS    = hcb_pkg::DEF_FREQ_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_cmd,
    input  wire logic [hcb_pkg::SYM_BITS-1:0]       i_symbol,
    input  wire logic [hcb_pkg::IN_FREQ_BITS-1:0]   i_freq,
    input  wire logic                               i_last,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [1:0]                              o_status,
    output logic [hcb_pkg::LEN_BITS-1:0]            o_code_length,
    output logic [hcb_pkg::CODE_BITS-1:0]           o_code_bits
);
    import hcb_pkg::*;

    localparam int LW = $clog2(NUM_LEAVES + 1);
    localparam int IW = $clog2(NUM_LEAVES);

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_BUILD, S_READ} t_state;

    logic [LEN_BITS-1:0]  len_mem [SYM_COUNT];
    logic [CODE_BITS-1:0] val_mem [SYM_COUNT];
    logic [SYM_COUNT-1:0] r_valid;

    t_state        r_state;
    logic [LW-1:0] r_count;
    logic [FREQ_BITS:0] r_total;
    logic          r_built, r_start, r_hit;
    logic [1:0]    r_status, r_rd_st;
    logic [LEN_BITS-1:0]  r_len_rd;
    logic [CODE_BITS-1:0] r_val_rd;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [LEN_BITS-1:0]  r_out_len;
    logic [CODE_BITS-1:0] r_out_bits;

    logic                 accept, ld_en, tree_done;
    logic [FREQ_BITS-1:0] f;
    logic [LW-1:0]        cnt;
    logic [FREQ_BITS:0]   tot, sum;
    logic [1:0]           bstat;
    t_tab_wr              tw;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign f          = FREQ_BITS'(i_freq);

    // A load after a build starts a new leaf set.
    assign cnt   = r_built ? '0 : r_count;
    assign tot   = r_built ? '0 : r_total;
    assign sum   = tot + (FREQ_BITS + 1)'(f);
    assign ld_en = accept && i_cmd == CMD_LOAD && f != '0 && cnt < LW'(NUM_LEAVES);

    assign bstat = (r_count == '0) ? ST_EMPTY :
                   (r_total[FREQ_BITS] ? ST_OVERFLOW : ST_OK);

    hcb_tree #(
        .NUM_LEAVES   (NUM_LEAVES),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .FREQ_BITS    (FREQ_BITS)
    ) u_tree (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld_en   (ld_en),
        .i_ld_idx  (cnt[IW-1:0]),
        .i_ld_sym  (i_symbol),
        .i_ld_freq (f),
        .i_start   (r_start),
        .i_count   (r_count),
        .o_done    (tree_done),
        .o_tw      (tw)
    );

    always_ff @(posedge i_clk) begin
        if (tw.en) begin
            len_mem[tw.sym] <= tw.len;
            val_mem[tw.sym] <= tw.bits;
        end
        if (accept) begin
            r_len_rd <= len_mem[i_symbol];
            r_val_rd <= val_mem[i_symbol];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_code_length = r_out_len;
    assign o_code_bits   = r_out_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_built     <= 1'b0;
            r_start     <= 1'b0;
            r_status    <= ST_OK;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (tw.en) begin
                r_valid[tw.sym] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_cmd == CMD_LOAD) begin
                        r_built <= 1'b0;
                        r_count <= ld_en ? cnt + 1'b1 : cnt;
                        if (ld_en) begin
                            r_total <= sum[FREQ_BITS] ? {1'b1, {FREQ_BITS{1'b0}}} : sum;
                        end else begin
                            r_total <= tot;
                        end
                        if (i_last) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_OK;
                            r_out_len    <= '0;
                            r_out_bits   <= '0;
                        end
                    end else if (accept) begin
                        r_hit   <= r_valid[i_symbol];
                        r_rd_st <= r_built ? r_status : ST_UNBUILT;
                        r_state <= S_READ;
                    end
                end
                S_CHECK: begin
                    r_built  <= 1'b1;
                    r_status <= bstat;
                    r_valid  <= '0;
                    if (bstat == ST_OK) begin
                        r_start <= 1'b1;
                        r_state <= S_BUILD;
                    end else begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= bstat;
                        r_out_len    <= '0;
                        r_out_bits   <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                S_BUILD: begin
                    if (tree_done) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= ST_OK;
                        r_out_len    <= '0;
                        r_out_bits   <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_out_valid  <= 1'b1;
                    r_out_status <= r_rd_st;
                    r_out_len    <= (r_rd_st == ST_OK && r_hit) ? r_len_rd : '0;
                    r_out_bits   <= (r_rd_st == ST_OK && r_hit) ? r_val_rd : '0;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
